// ----- hw/rtl/twr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the TCP Reno/NewReno window engine.
// Used by twr_div, twr_dp, twr_ctrl and tcp_reno_newreno_window.
package twr_pkg;

	localparam int unsigned CAP_SEGMENTS_DEF = 65535;
	localparam logic [15:0] DEFAULT_SEG = 16'd1460;
	localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
	localparam logic [15:0] DUP_LIMIT   = 16'd3;
	localparam logic [15:0] DUP_MAX     = 16'hFFFF;
	localparam int unsigned DIV_STEPS   = 32;

	typedef enum logic [2:0] {
		MODE_NEW_ACK   = 3'd0,
		MODE_DUP_ACK   = 3'd1,
		MODE_TIMEOUT   = 3'd2,
		MODE_RTT       = 3'd3,
		MODE_RECOV_PNT = 3'd4
	} mode_t;

	typedef struct packed {
		logic capture;
		logic prep;
		logic div_start;
		logic apply;
		logic load_out;
	} twr_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} twr_stat_t;

endpackage

// ----- hw/rtl/twr_div.sv -----
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on twr_pkg for the step count.
module twr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	import twr_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic [31:0]      rem_q;
	logic [31:0]      quo_q;
	logic [31:0]      dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [32:0]      shifted;
	logic [33:0]      trial;

	assign shifted = {rem_q, quo_q[31]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[33]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- hw/rtl/twr_dp.sv -----
`timescale 1ns / 1ps
// Datapath: window, threshold and RTT state, event operands and result beat.
// Depends on twr_pkg and twr_div; driven by commands from twr_ctrl.
module twr_dp #(
	parameter int unsigned CAP_SEGMENTS = twr_pkg::CAP_SEGMENTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  twr_pkg::twr_cmd_t  cmd,
	output twr_pkg::twr_stat_t stat,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_data,
	input  logic [2:0]       mode,
	input  logic [31:0]      bytes_acked,
	input  logic [31:0]      ack_seq,
	input  logic [31:0]      rtt_sample,
	input  logic [31:0]      bytes_in_flight,
	output logic [31:0]      window,
	output logic [31:0]      slow_start_threshold,
	output logic             retransmit,
	output logic             in_recovery,
	output logic             in_slow_start,
	output logic [31:0]      smoothed_rtt,
	output logic [31:0]      rtt_variation,
	output logic [31:0]      min_rtt,
	output logic [31:0]      loss_events,
	output logic [31:0]      timeout_count
);
	import twr_pkg::*;

	localparam int CAP_W = $clog2(CAP_SEGMENTS + 1);

	// configuration and state
	logic [15:0] seg_q;
	logic [31:0] cwnd_q, thr_q, rp_q, srtt_q, rttvar_q, floor_q, losses_q, timeouts_q;
	logic        slow_q, rec_q, rexmit_q;
	logic [15:0] dup_q;

	// captured event
	logic [2:0]  mode_q;
	logic [31:0] acked_q, seq_q, rtt_q, flight_q;
	logic [15:0] s_q;

	// prepared operands
	logic [31:0]        sq_q, cap_q, lt_q, pc_q, mag_q;
	logic [17:0]        s3_q;
	logic signed [32:0] diff_q;

	// result beat
	logic [31:0] win_o_q, thr_o_q, srtt_o_q, var_o_q, floor_o_q, loss_o_q, to_o_q;
	logic        rex_o_q, rec_o_q, slow_o_q;

	logic               need_div;
	logic               div_done;
	logic [15:0]        s_eff;
	logic [31:0]        lw;
	logic [16:0]        two_s;
	logic [CAP_W+15:0]  cap_prod;
	logic [31:0]        quo, inc;
	logic [32:0]        w_ss, w_ca, w_new, sum_part, sum_loss, sum_infl;
	logic [15:0]        dup_n;
	logic signed [34:0] ns;
	logic signed [32:0] mv;
	logic signed [33:0] nv;
	logic [31:0]        ns_c, nv_c;

	twr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sq_q),
		.divisor  (cwnd_q == '0 ? 32'd1 : cwnd_q),
		.done     (div_done),
		.quotient (quo)
	);

	assign s_eff    = (seg_q == '0) ? DEFAULT_SEG : seg_q;
	assign need_div = (mode_q == MODE_NEW_ACK) && (acked_q != '0) && !rec_q
		&& (cwnd_q >= thr_q);
	assign stat     = {need_div, div_done};

	// operand preparation
	assign lw       = (flight_q != '0 && flight_q < cwnd_q) ? flight_q : cwnd_q;
	assign two_s    = {s_q, 1'b0};
	assign cap_prod = (CAP_W+16)'(CAP_SEGMENTS) * (CAP_W+16)'(s_q);

	// update arithmetic
	assign inc      = (quo == '0) ? 32'd1 : quo;
	assign w_ss     = {1'b0, cwnd_q} + {17'b0, s_q};
	assign w_ca     = {1'b0, cwnd_q} + {1'b0, inc};
	assign w_new    = (cwnd_q < thr_q) ? w_ss : w_ca;
	assign sum_part = {1'b0, pc_q} + {17'b0, s_q};
	assign sum_loss = {1'b0, lt_q} + {15'b0, s3_q};
	assign sum_infl = {1'b0, cwnd_q} + {17'b0, s_q};
	assign dup_n    = (dup_q < DUP_MAX) ? dup_q + 16'd1 : dup_q;

	assign ns   = 35'(signed'({1'b0, srtt_q})) + 35'(diff_q >>> 3);
	assign ns_c = (ns[34] || ns == '0) ? 32'd1 : ((ns[33:32] != '0) ? ALL_ONES : ns[31:0]);
	assign mv   = signed'({1'b0, mag_q}) - signed'({1'b0, rttvar_q});
	assign nv   = 34'(signed'({1'b0, rttvar_q})) + 34'(mv >>> 2);
	assign nv_c = nv[33] ? 32'd0 : (nv[32] ? ALL_ONES : nv[31:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q      <= DEFAULT_SEG;
			cwnd_q     <= 32'({DEFAULT_SEG, 1'b0});
			thr_q      <= ALL_ONES;
			slow_q     <= 1'b1;
			rec_q      <= 1'b0;
			rp_q       <= '0;
			dup_q      <= '0;
			srtt_q     <= '0;
			rttvar_q   <= '0;
			floor_q    <= ALL_ONES;
			losses_q   <= '0;
			timeouts_q <= '0;
			rexmit_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				seg_q <= cfg_data;
			end
			if (cmd.apply) begin
				rexmit_q <= 1'b0;
				case (mode_q)
					MODE_NEW_ACK: begin
						if (acked_q != '0) begin
							if (rec_q) begin
								if (seq_q >= rp_q) begin
									cwnd_q <= thr_q;
									rec_q  <= 1'b0;
									dup_q  <= '0;
								end else begin
									cwnd_q   <= sum_part[32] ? ALL_ONES : sum_part[31:0];
									rexmit_q <= 1'b1;
								end
							end else begin
								dup_q  <= '0;
								slow_q <= (cwnd_q < thr_q);
								cwnd_q <= (w_new > {1'b0, cap_q}) ? cap_q : w_new[31:0];
							end
						end
					end
					MODE_DUP_ACK: begin
						dup_q <= dup_n;
						if (dup_n == DUP_LIMIT) begin
							thr_q    <= lt_q;
							cwnd_q   <= sum_loss[32] ? ALL_ONES : sum_loss[31:0];
							slow_q   <= 1'b0;
							rec_q    <= 1'b1;
							losses_q <= losses_q + 32'd1;
							rexmit_q <= 1'b1;
						end else if (dup_n > DUP_LIMIT && rec_q) begin
							cwnd_q <= sum_infl[32] ? ALL_ONES : sum_infl[31:0];
						end
					end
					MODE_TIMEOUT: begin
						losses_q   <= losses_q + 32'd1;
						timeouts_q <= timeouts_q + 32'd1;
						thr_q      <= lt_q;
						cwnd_q     <= 32'(s_q);
						slow_q     <= 1'b1;
						rec_q      <= 1'b0;
						dup_q      <= '0;
						rp_q       <= '0;
						rexmit_q   <= 1'b1;
					end
					MODE_RTT: begin
						if (rtt_q != '0) begin
							if (rtt_q < floor_q) begin
								floor_q <= rtt_q;
							end
							if (srtt_q == '0) begin
								srtt_q   <= rtt_q;
								rttvar_q <= {1'b0, rtt_q[31:1]};
							end else begin
								srtt_q   <= ns_c;
								rttvar_q <= nv_c;
							end
						end
					end
					MODE_RECOV_PNT: begin
						rp_q <= seq_q;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q   <= mode;
			acked_q  <= bytes_acked;
			seq_q    <= ack_seq;
			rtt_q    <= rtt_sample;
			flight_q <= bytes_in_flight;
			s_q      <= s_eff;
		end
		if (cmd.prep) begin
			sq_q   <= {16'd0, s_q} * {16'd0, s_q};
			cap_q  <= 32'(cap_prod);
			lt_q   <= ({1'b0, lw[31:1]} < 32'(two_s)) ? 32'(two_s) : {1'b0, lw[31:1]};
			pc_q   <= (cwnd_q > 32'(s_q)) ? cwnd_q - 32'(s_q) : cwnd_q;
			s3_q   <= 18'(two_s) + 18'(s_q);
			diff_q <= signed'({1'b0, rtt_q}) - signed'({1'b0, srtt_q});
			mag_q  <= (rtt_q >= srtt_q) ? rtt_q - srtt_q : srtt_q - rtt_q;
		end
		if (cmd.load_out) begin
			win_o_q   <= (cwnd_q < 32'(s_q)) ? 32'(s_q) : cwnd_q;
			thr_o_q   <= thr_q;
			rex_o_q   <= rexmit_q;
			rec_o_q   <= rec_q;
			slow_o_q  <= slow_q;
			srtt_o_q  <= srtt_q;
			var_o_q   <= rttvar_q;
			floor_o_q <= floor_q;
			loss_o_q  <= losses_q;
			to_o_q    <= timeouts_q;
		end
	end

	assign window               = win_o_q;
	assign slow_start_threshold = thr_o_q;
	assign retransmit           = rex_o_q;
	assign in_recovery          = rec_o_q;
	assign in_slow_start        = slow_o_q;
	assign smoothed_rtt         = srtt_o_q;
	assign rtt_variation        = var_o_q;
	assign min_rtt              = floor_o_q;
	assign loss_events          = loss_o_q;
	assign timeout_count        = to_o_q;

endmodule

// ----- hw/rtl/twr_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences capture, operand prep, divide, update and result beat.
// Depends on twr_pkg for the command and status structs.
module twr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output twr_pkg::twr_cmd_t  cmd,
	input  twr_pkg::twr_stat_t stat
);
	import twr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_DIV_GO,
		S_DIV_WAIT,
		S_APPLY,
		S_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	assign cmd.capture   = (state_q == S_IDLE) && in_valid;
	assign cmd.prep      = (state_q == S_PREP);
	assign cmd.div_start = (state_q == S_DIV_GO);
	assign cmd.apply     = (state_q == S_APPLY);
	assign cmd.load_out  = (state_q == S_OUT) && slot_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= stat.need_div ? S_DIV_GO : S_APPLY;
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (stat.div_done) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/tcp_reno_newreno_window.sv -----
`timescale 1ns / 1ps
// Top level of the TCP Reno/NewReno congestion window engine.
// Depends on twr_pkg, twr_ctrl, twr_dp (which holds twr_div).

// One event in, one result beat out; the input stalls until the last event is
// through. A new ACK in congestion avoidance runs the 32-step radix-2 divider
// that forms segment_size^2 / cwnd. The result sits in an output register, so
// a new event is taken while the previous beat waits. The user must write
// segment_size over the cfg channel only while the engine is idle; the block
// does not enforce it. Zero means 1460 bytes; the cap is CAP_SEGMENTS segments.
module tcp_reno_newreno_window #(
	parameter int unsigned CAP_SEGMENTS = twr_pkg::CAP_SEGMENTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [31:0] bytes_acked,
	input  logic [31:0] ack_seq,
	input  logic [31:0] rtt_sample,
	input  logic [31:0] bytes_in_flight,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] window,
	output logic [31:0] slow_start_threshold,
	output logic        retransmit,
	output logic        in_recovery,
	output logic        in_slow_start,
	output logic [31:0] smoothed_rtt,
	output logic [31:0] rtt_variation,
	output logic [31:0] min_rtt,
	output logic [31:0] loss_events,
	output logic [31:0] timeout_count
);
	import twr_pkg::*;

	twr_cmd_t  cmd;
	twr_stat_t stat;

	assign cfg_ready = 1'b1;

	twr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	twr_dp #(
		.CAP_SEGMENTS (CAP_SEGMENTS)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.stat                 (stat),
		.cfg_we               (cfg_valid && cfg_ready),
		.cfg_data             (cfg_data),
		.mode                 (mode),
		.bytes_acked          (bytes_acked),
		.ack_seq              (ack_seq),
		.rtt_sample           (rtt_sample),
		.bytes_in_flight      (bytes_in_flight),
		.window               (window),
		.slow_start_threshold (slow_start_threshold),
		.retransmit           (retransmit),
		.in_recovery          (in_recovery),
		.in_slow_start        (in_slow_start),
		.smoothed_rtt         (smoothed_rtt),
		.rtt_variation        (rtt_variation),
		.min_rtt              (min_rtt),
		.loss_events          (loss_events),
		.timeout_count        (timeout_count)
	);

endmodule

// ----- tb/tcp_reno_newreno_window_tb.sv -----
`timescale 1ns / 1ps
// Testbench for tcp_reno_newreno_window: directed and random events against an in-bench window predictor.
// Depends on twr_pkg and the tcp_reno_newreno_window RTL; reads no files.
module tcp_reno_newreno_window_tb;
	import twr_pkg::*;

	localparam logic [2:0] MODE_SPARE_LO = 3'd5;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] acked;
		logic [31:0] seq;
		logic [31:0] rtt;
		logic [31:0] flight;
	} ack_event_t;

	typedef struct packed {
		logic [31:0] window;
		logic [31:0] ssthresh;
		logic        rexmit;
		logic        recov;
		logic        slow;
		logic [31:0] srtt;
		logic [31:0] rttvar;
		logic [31:0] min_rtt;
		logic [31:0] losses;
		logic [31:0] timeouts;
	} window_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  mode = 3'd0;
	logic [31:0] bytes_acked = 32'd0;
	logic [31:0] ack_seq = 32'd0;
	logic [31:0] rtt_sample = 32'd0;
	logic [31:0] bytes_in_flight = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] window;
	logic [31:0] slow_start_threshold;
	logic        retransmit;
	logic        in_recovery;
	logic        in_slow_start;
	logic [31:0] smoothed_rtt;
	logic [31:0] rtt_variation;
	logic [31:0] min_rtt;
	logic [31:0] loss_events;
	logic [31:0] timeout_count;

	// predicted engine state
	logic [15:0] seg_cfg = DEFAULT_SEG;
	logic [31:0] win_bytes = 32'd2920;
	logic [31:0] thresh_bytes = ALL_ONES;
	logic        slow_on = 1'b1;
	logic        recov_on = 1'b0;
	logic [31:0] recov_point = 32'd0;
	logic [15:0] dup_seen = 16'd0;
	logic [31:0] srtt_us = 32'd0;
	logic [31:0] rttvar_us = 32'd0;
	logic [31:0] rtt_floor_us = ALL_ONES;
	logic [31:0] loss_total = 32'd0;
	logic [31:0] timeout_total = 32'd0;

	ack_event_t     pending_events[$];
	window_report_t expected_reports[$];
	ack_event_t     on_bus;
	int             issued = 0;
	int             checked = 0;
	int             failures = 0;
	int             hold_left = 0;
	bit             burst_done = 1'b0;
	bit             calm = 1'b0;

	tcp_reno_newreno_window uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.bytes_acked(bytes_acked),
		.ack_seq(ack_seq),
		.rtt_sample(rtt_sample),
		.bytes_in_flight(bytes_in_flight),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.window(window),
		.slow_start_threshold(slow_start_threshold),
		.retransmit(retransmit),
		.in_recovery(in_recovery),
		.in_slow_start(in_slow_start),
		.smoothed_rtt(smoothed_rtt),
		.rtt_variation(rtt_variation),
		.min_rtt(min_rtt),
		.loss_events(loss_events),
		.timeout_count(timeout_count)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("[tcp_reno_newreno_window] ERROR");
		$finish;
	end

	function automatic logic [31:0] eff_seg();
		return (seg_cfg == 16'd0) ? {16'd0, DEFAULT_SEG} : {16'd0, seg_cfg};
	endfunction

	function automatic logic [31:0] sat_sum(input logic [63:0] v);
		return (v > {32'd0, ALL_ONES}) ? ALL_ONES : v[31:0];
	endfunction

	function automatic logic [31:0] loss_thresh(input logic [31:0] flight);
		logic [31:0] w;
		logic [31:0] t;
		logic [31:0] two_seg;
		w = win_bytes;
		if (flight != 32'd0 && flight < w)
			w = flight;
		t = w >> 1;
		two_seg = eff_seg() << 1;
		return (t < two_seg) ? two_seg : t;
	endfunction

	function automatic window_report_t step_window(input ack_event_t ev);
		logic [63:0]    s;
		logic [63:0]    w;
		logic [63:0]    inc;
		logic [63:0]    cap;
		longint         diff;
		longint         mag;
		longint         ns;
		longint         nv;
		logic           rexmit;
		window_report_t rep;
		s = {32'd0, eff_seg()};
		rexmit = 1'b0;
		case (ev.mode)
		MODE_NEW_ACK: begin
			if (ev.acked != 32'd0 && recov_on) begin
				if (ev.seq >= recov_point) begin
					win_bytes = thresh_bytes;
					recov_on = 1'b0;
					dup_seen = 16'd0;
				end else begin
					if (win_bytes > s[31:0])
						win_bytes = win_bytes - s[31:0];
					win_bytes = sat_sum({32'd0, win_bytes} + s);
					rexmit = 1'b1;
				end
			end else if (ev.acked != 32'd0) begin
				dup_seen = 16'd0;
				cap = 64'(CAP_SEGMENTS_DEF) * s;
				w = {32'd0, win_bytes};
				if (w < {32'd0, thresh_bytes}) begin
					w = w + s;
					slow_on = 1'b1;
				end else begin
					inc = (s * s) / ((w != 64'd0) ? w : 64'd1);
					if (inc < 64'd1)
						inc = 64'd1;
					w = w + inc;
					slow_on = 1'b0;
				end
				if (w > cap)
					w = cap;
				win_bytes = sat_sum(w);
			end
		end
		MODE_DUP_ACK: begin
			if (dup_seen != DUP_MAX)
				dup_seen = dup_seen + 16'd1;
			if (dup_seen == DUP_LIMIT) begin
				thresh_bytes = loss_thresh(ev.flight);
				win_bytes = sat_sum({32'd0, thresh_bytes} + 64'd3 * s);
				slow_on = 1'b0;
				recov_on = 1'b1;
				loss_total = loss_total + 32'd1;
				rexmit = 1'b1;
			end else if (dup_seen > DUP_LIMIT && recov_on) begin
				win_bytes = sat_sum({32'd0, win_bytes} + s);
			end
		end
		MODE_TIMEOUT: begin
			loss_total = loss_total + 32'd1;
			timeout_total = timeout_total + 32'd1;
			thresh_bytes = loss_thresh(ev.flight);
			win_bytes = s[31:0];
			slow_on = 1'b1;
			recov_on = 1'b0;
			dup_seen = 16'd0;
			recov_point = 32'd0;
			rexmit = 1'b1;
		end
		MODE_RTT: begin
			if (ev.rtt != 32'd0) begin
				if (ev.rtt < rtt_floor_us)
					rtt_floor_us = ev.rtt;
				if (srtt_us == 32'd0) begin
					srtt_us = ev.rtt;
					rttvar_us = ev.rtt >> 1;
				end else begin
					diff = longint'(ev.rtt) - longint'(srtt_us);
					mag = (diff < 0) ? -diff : diff;
					ns = longint'(srtt_us) + (diff >>> 3);
					if (ns < 1)
						ns = 1;
					if (ns > longint'(ALL_ONES))
						ns = longint'(ALL_ONES);
					srtt_us = ns[31:0];
					nv = longint'(rttvar_us) + ((mag - longint'(rttvar_us)) >>> 2);
					if (nv < 0)
						nv = 0;
					if (nv > longint'(ALL_ONES))
						nv = longint'(ALL_ONES);
					rttvar_us = nv[31:0];
				end
			end
		end
		MODE_RECOV_PNT: begin
			recov_point = ev.seq;
		end
		default: begin
		end
		endcase
		rep.window = (win_bytes < s[31:0]) ? s[31:0] : win_bytes;
		rep.ssthresh = thresh_bytes;
		rep.rexmit = rexmit;
		rep.recov = recov_on;
		rep.slow = slow_on;
		rep.srtt = srtt_us;
		rep.rttvar = rttvar_us;
		rep.min_rtt = rtt_floor_us;
		rep.losses = loss_total;
		rep.timeouts = timeout_total;
		return rep;
	endfunction

	function automatic void add_event(input logic [2:0] m, input logic [31:0] acked,
			input logic [31:0] seq, input logic [31:0] rtt, input logic [31:0] flight);
		ack_event_t ev;
		ev.mode = m;
		ev.acked = acked;
		ev.seq = seq;
		ev.rtt = rtt;
		ev.flight = flight;
		pending_events.push_back(ev);
		issued++;
	endfunction

	function automatic logic [31:0] pick_acked();
		logic [31:0] v;
		v = $urandom;
		if ($urandom_range(15, 0) == 0)
			return 32'd0;
		return (v == 32'd0) ? 32'd1 : v;
	endfunction

	function automatic logic [31:0] pick_flight();
		case ($urandom_range(3, 0))
		0: return 32'd0;
		1: return $urandom_range(4000, 1);
		2: return $urandom_range(200000, 1);
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_rtt();
		int r;
		r = $urandom_range(9, 0);
		if (r == 0)
			return 32'd0;
		if (r < 6)
			return $urandom_range(500000, 1);
		return $urandom;
	endfunction

	// recovery episode (set point, dup acks, partial acks, full ack, growth); else acks, RTTs, timeout, any mode
	function automatic void queue_random_block();
		logic [31:0] pt;
		int          r;
		int          n;
		r = $urandom_range(99, 0);
		if (r < 55) begin
			pt = $urandom;
			add_event(MODE_RECOV_PNT, $urandom, pt, $urandom, $urandom);
			n = $urandom_range(7, 3);
			if ($urandom_range(7, 0) == 0)
				n = $urandom_range(2, 1);
			repeat (n) add_event(MODE_DUP_ACK, $urandom, $urandom, $urandom, pick_flight());
			if (pt != 32'd0)
				repeat ($urandom_range(3, 0))
					add_event(MODE_NEW_ACK, pick_acked(), $urandom_range(pt - 32'd1, 0),
						$urandom, $urandom);
			if ($urandom_range(9, 0) == 0)
				add_event(MODE_TIMEOUT, $urandom, $urandom, $urandom, pick_flight());
			if ($urandom_range(7, 0) != 0)
				add_event(MODE_NEW_ACK, pick_acked(),
					($urandom_range(3, 0) == 0) ? pt : $urandom_range(ALL_ONES, pt),
					$urandom, $urandom);
			repeat ($urandom_range(5, 0))
				add_event(MODE_NEW_ACK, pick_acked(), $urandom, $urandom, $urandom);
		end else if (r < 75) begin
			repeat ($urandom_range(8, 2))
				add_event(MODE_NEW_ACK, pick_acked(), $urandom, $urandom, $urandom);
		end else if (r < 85) begin
			repeat ($urandom_range(4, 1))
				add_event(MODE_RTT, $urandom, $urandom, pick_rtt(), $urandom);
		end else if (r < 90) begin
			add_event(MODE_TIMEOUT, $urandom, $urandom, $urandom, pick_flight());
		end else begin
			add_event(3'($urandom_range(MODE_SPARE_HI, 0)), $urandom, $urandom, $urandom,
				$urandom);
		end
	endfunction

	function automatic void queue_directed();
		add_event(MODE_NEW_ACK, 32'd0, 32'd0, 32'd0, 32'd0);
		add_event(MODE_NEW_ACK, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
		add_event(MODE_RTT, 32'd0, 32'd0, 32'd0, 32'd0);
		add_event(MODE_RTT, 32'd0, 32'd0, 32'd1000, 32'd0);
		add_event(MODE_RTT, 32'd0, 32'd0, ALL_ONES, 32'd0);
		add_event(MODE_RTT, 32'd0, 32'd0, 32'd1, 32'd0);
		add_event(MODE_SPARE_LO, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
		add_event(MODE_SPARE_HI, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
		add_event(MODE_RECOV_PNT, 32'd0, 32'h8000_0000, 32'd0, 32'd0);
		repeat (3) add_event(MODE_DUP_ACK, 32'd0, 32'd0, 32'd0, 32'd0);
		repeat (2) add_event(MODE_DUP_ACK, 32'd0, 32'd0, 32'd0, ALL_ONES);
		add_event(MODE_NEW_ACK, 32'd1, 32'd5, 32'd0, 32'd0);
		add_event(MODE_NEW_ACK, ALL_ONES, 32'h8000_0000, 32'd0, 32'd0);
		add_event(MODE_NEW_ACK, 32'd100, 32'd0, 32'd0, 32'd0);
		add_event(MODE_TIMEOUT, 32'd0, 32'd0, 32'd0, ALL_ONES);
		add_event(MODE_TIMEOUT, 32'd0, 32'd0, 32'd0, 32'd1);
		repeat (2) add_event(MODE_NEW_ACK, 32'd1460, 32'd0, 32'd0, 32'd0);
		repeat (3) add_event(MODE_DUP_ACK, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF);
	endfunction

	task automatic write_segment(input logic [15:0] v);
		@(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		seg_cfg = v;
	endtask

	// hold until every issued event has reported, then let the engine settle
	task automatic drain();
		while (checked != issued)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_reports.push_back(step_window(on_bus));
			if (!in_valid || !in_stall) begin
				if (pending_events.size() != 0 && (calm || $urandom_range(99, 0) >= 11)) begin
					on_bus = pending_events.pop_front();
					mode <= on_bus.mode;
					bytes_acked <= on_bus.acked;
					ack_seq <= on_bus.seq;
					rtt_sample <= on_bus.rtt;
					bytes_in_flight <= on_bus.flight;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		window_report_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: result beat with nothing expected, window %h", $time, window);
					failures++;
				end else begin
					want = expected_reports.pop_front();
					check_field("window", want.window, window);
					check_field("slow_start_threshold", want.ssthresh, slow_start_threshold);
					check_field("retransmit", {31'd0, want.rexmit}, {31'd0, retransmit});
					check_field("in_recovery", {31'd0, want.recov}, {31'd0, in_recovery});
					check_field("in_slow_start", {31'd0, want.slow}, {31'd0, in_slow_start});
					check_field("smoothed_rtt", want.srtt, smoothed_rtt);
					check_field("rtt_variation", want.rttvar, rtt_variation);
					check_field("min_rtt", want.min_rtt, min_rtt);
					check_field("loss_events", want.losses, loss_events);
					check_field("timeout_count", want.timeouts, timeout_count);
					checked++;
				end
			end
			// hold off once long enough to back the engine up into its input
			if (hold_left > 0) begin
				hold_left--;
			end else if (!burst_done && checked >= 400) begin
				hold_left = 250;
				burst_done = 1'b1;
			end
			out_stall <= (hold_left > 0) || (!calm && $urandom_range(99, 0) < 11);
		end
	end

	initial begin
		logic [15:0] seg_plan [6];
		int          target;
		seg_plan = '{16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(65534, 2)), 16'd536, DEFAULT_SEG};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		queue_directed();
		drain();
		foreach (seg_plan[p]) begin
			write_segment(seg_plan[p]);
			calm = (p == 2);
			target = issued + 270;
			while (issued < target)
				queue_random_block();
			drain();
		end
		calm = 1'b0;
		if (failures == 0 && expected_reports.size() == 0) begin
			$display("[tcp_reno_newreno_window] OK");
		end else begin
			$display("[tcp_reno_newreno_window] ERROR");
		end
		$finish;
	end

endmodule
